// ===== rtl/wfsa_pkg.sv =====
// wfsa_pkg: shared types and constants for the worst-fit segment allocator
// used by the controller, the datapath and the top level
`default_nettype none
package wfsa_pkg;
  localparam int unsigned SegSlotsDef = 64;
  localparam int unsigned AddrBitsDef = 16;
  localparam logic [15:0] TotalBytesRst = 16'd1024;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_COMPACT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_CMP,
    S_TAIL,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic init;
    logic start;
    logic scan_step;
    logic shift_step;
    logic place;
    logic rel_step;
    logic cmp_step;
    logic tail;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic found;
    logic exact;
    logic full;
    logic shift_done;
    logic rel_hit;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/worst_fit_segment_allocator_core.sv =====
// worst_fit_segment_allocator_core: top level of the worst-fit allocator
// depends on wfsa_pkg, wfsa_ctrl, wfsa_datapath
//
// One command at a time; each walks the segment table through a single
// memory read port at one entry per cycle. A release that finds its owner
// stops its walk early, and a request that splits a hole first moves the
// entries above it up by one. The next transaction is taken only once the
// result has been accepted, and a stalled result holds the input off.
// Writing cfg_wdata sets the memory size and resets the table to one hole.
`default_nettype none
module worst_fit_segment_allocator_core
  import wfsa_pkg::*;
#(
  parameter int unsigned SEG_SLOTS = SegSlotsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // operation, owner_id, request_size
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // status, placed_start, segment_count
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  cmd_t    cmd;
  sts_t    sts;
  status_t st;
  logic    busy, fire;
  logic [15:0] tb_r;
  logic [1:0]  o_st;
  logic [15:0] o_ps;
  logic [6:0]  o_sc;

  always_ff @(posedge clk) begin
    if (!rst_n) tb_r <= TotalBytesRst;
    else if (cfg_we) tb_r <= cfg_wdata;
  end

  assign in_tready = !busy;
  assign fire = in_tvalid && in_tready;

  wfsa_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(fire), .op(in_tdata[1:0]), .req_size(in_tdata[25:10]),
    .cfg_we, .out_tready, .out_tvalid, .busy, .sts, .cmd, .status(st)
  );

  wfsa_datapath #(.SEG_SLOTS(SEG_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .total_bytes(cfg_we ? cfg_wdata : tb_r),
    .op(in_tdata[1:0]), .owner_id(in_tdata[9:2]), .request_size(in_tdata[25:10]),
    .status_in(st), .status(o_st), .placed_start(o_ps), .segment_count(o_sc)
  );

  assign out_tdata = {7'd0, o_sc, o_ps, o_st};
endmodule
`default_nettype wire

// ===== rtl/wfsa_datapath.sv =====
// wfsa_datapath: segment table memory, scan counters and result registers
// depends on wfsa_pkg
`default_nettype none
module wfsa_datapath
  import wfsa_pkg::*;
#(
  parameter int unsigned SEG_SLOTS = SegSlotsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [15:0] total_bytes,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  owner_id,
  input  wire logic [15:0] request_size,
  input  wire status_t     status_in,
  output logic [1:0]       status,
  output logic [15:0]      placed_start,
  output logic [6:0]       segment_count
);
  localparam int unsigned ADDR_BITS = AddrBitsDef;
  localparam int unsigned IW = $clog2(SEG_SLOTS);
  localparam int unsigned CW = $clog2(SEG_SLOTS + 1);
  localparam int unsigned EW = 1 + 8 + 2 * ADDR_BITS;

  // entry: {is_proc, owner, start, size}
  logic [EW-1:0] mem [SEG_SLOTS];
  logic [EW-1:0] rd_r;

  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] i_r;
  logic [CW-1:0] n_r;
  logic [ADDR_BITS:0] addr_r;
  logic [IW-1:0] best_r;
  logic [ADDR_BITS-1:0] best_size_r, best_start_r;
  logic          found_r;
  logic [ADDR_BITS-1:0] want_r;
  logic [7:0]    own_r;
  logic [1:0]    op_r;
  logic [ADDR_BITS-1:0] tb;

  logic                 e_proc;
  logic [7:0]           e_own;
  logic [ADDR_BITS-1:0] e_start, e_size;
  logic                 rd_valid_r;

  assign tb = ADDR_BITS'(total_bytes);
  assign {e_proc, e_own, e_start, e_size} = rd_r;

  // read address: scan/release/compact walk i_r, shift reads one entry ahead
  logic [IW-1:0] raddr;
  assign raddr = (cmd.shift_step || (cmd.scan_step && sts.scan_last)) ?
                 IW'(i_r - 1'b1) : IW'(i_r);

  logic [EW-1:0] wdata;
  logic [IW-1:0] waddr;
  logic          we;
  logic [ADDR_BITS:0] addr_sum;
  assign addr_sum = addr_r + (ADDR_BITS+1)'(e_size);

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.init) begin
      we = 1'b1;
      wdata = {1'b0, 8'd0, {ADDR_BITS{1'b0}}, tb};
    end else if (cmd.shift_step) begin
      we = 1'b1;
      waddr = IW'(i_r + 1'b1);
      wdata = rd_r;
    end else if (cmd.rel_step) begin
      we = rd_valid_r && e_proc && (e_own == own_r);
      waddr = IW'(i_r - 1'b1);
      wdata = {1'b0, e_own, e_start, e_size};
    end else if (cmd.cmp_step) begin
      we = rd_valid_r && e_proc;
      waddr = IW'(n_r);
      wdata = {1'b1, e_own, addr_r[ADDR_BITS-1:0], e_size};
    end else if (cmd.tail) begin
      we = (n_r < CW'(SEG_SLOTS)) && (n_r == '0 || addr_r < (ADDR_BITS+1)'(tb));
      waddr = IW'(n_r);
      wdata = {1'b0, 8'd0, addr_r[ADDR_BITS-1:0],
               (addr_r < (ADDR_BITS+1)'(tb)) ?
               ADDR_BITS'((ADDR_BITS+1)'(tb) - addr_r) : '0};
    end
  end

  // place writes owned entry at best on a second port, new hole at best+1 if not exact
  logic          we2;
  logic [IW-1:0] waddr2;
  logic [EW-1:0] wdata2;
  always_comb begin
    we2 = cmd.place;
    waddr2 = best_r;
    wdata2 = {1'b1, own_r, best_start_r, want_r};
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (we2) mem[waddr2] <= wdata2;
    if (cmd.place && (best_size_r != want_r))
      mem[IW'(best_r + 1'b1)] <= {1'b0, 8'd0, ADDR_BITS'(best_start_r + want_r),
                                   ADDR_BITS'(best_size_r - want_r)};
    rd_r <= mem[raddr];
  end

  logic scan_hit;
  assign scan_hit = rd_valid_r && !e_proc && (e_size >= want_r) &&
                    (!found_r || e_size > best_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= CW'(1);
      found_r <= 1'b0;
      rd_valid_r <= 1'b0;
      i_r <= '0;
      n_r <= '0;
    end else begin
      used_r <= used_nxt;
      if (cmd.start) begin
        i_r <= '0;
        n_r <= '0;
        addr_r <= '0;
        found_r <= 1'b0;
        rd_valid_r <= 1'b0;
        want_r <= ADDR_BITS'(request_size);
        own_r <= owner_id;
        op_r <= op;
      end else if (cmd.scan_step || cmd.rel_step || cmd.cmp_step) begin
        rd_valid_r <= (i_r < used_r);
        if (i_r < used_r) i_r <= i_r + 1'b1;
        if (cmd.scan_step && scan_hit) begin
          found_r <= 1'b1;
          best_r <= IW'(i_r - 1'b1);
          best_size_r <= e_size;
          best_start_r <= e_start;
        end
        if (cmd.rel_step && we) rd_valid_r <= 1'b0;
        if (cmd.rel_step && we) i_r <= used_r;
        if (cmd.cmp_step && we) begin
          n_r <= n_r + 1'b1;
          addr_r <= addr_sum;
        end
      end else if (cmd.shift_step) begin
        i_r <= i_r - 1'b1;
      end
      if (cmd.scan_step && sts.scan_last) begin
        // scan finished; point at last entry for the shift
        i_r <= used_r - 1'b1;
      end
    end
  end

  logic rel_hit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rel_hit_r <= 1'b0;
    else if (cmd.start) rel_hit_r <= 1'b0;
    else if (cmd.rel_step && we) rel_hit_r <= 1'b1;
  end

  always_comb begin
    used_nxt = used_r;
    if (cmd.init) used_nxt = CW'(1);
    else if (cmd.place && (best_size_r != want_r)) used_nxt = used_r + 1'b1;
    else if (cmd.tail) used_nxt = we ? n_r + 1'b1 : n_r;
  end

  // scan_last: the pipeline has consumed every entry
  assign sts.scan_last  = !(i_r < used_r) && !rd_valid_r;
  assign sts.found      = found_r;
  assign sts.exact      = (best_size_r == want_r);
  assign sts.full       = (used_r >= CW'(SEG_SLOTS));
  assign sts.shift_done = (i_r <= CW'(best_r));
  assign sts.rel_hit    = rel_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= status_in;
      placed_start <= (status_in == ST_DONE && op_r == OP_REQUEST)
                      ? 16'(best_start_r) : 16'd0;
      segment_count <= 7'(used_r);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wfsa_ctrl.sv =====
// wfsa_ctrl: command sequencer for the allocator
// depends on wfsa_pkg
`default_nettype none
module wfsa_ctrl
  import wfsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [1:0] op,
  input  wire logic [15:0] req_size,
  input  wire logic       cfg_we,
  input  wire logic       out_tready,
  output logic            out_tvalid,
  output logic            busy,
  input  wire sts_t       sts,
  output cmd_t            cmd,
  output status_t         status
);
  state_t state_r, state_nxt;
  op_t    op_r;
  logic   zero_r;
  logic   init_r;
  logic   full_r;
  logic   out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      init_r <= 1'b0;
    end
    if (in_fire) begin
      op_r <= op_t'(op);
      zero_r <= (req_size == 16'd0);
    end
    if (state_r == S_SCAN && sts.scan_last) full_r <= sts.full;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) begin
        case (op_t'(op))
          OP_REQUEST: state_nxt = S_SCAN;
          OP_RELEASE: state_nxt = S_SCAN;
          OP_COMPACT: state_nxt = S_CMP;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_SCAN: if (sts.scan_last) begin
        if (op_r != OP_REQUEST || zero_r || !sts.found || sts.exact) state_nxt = S_OUT;
        else if (sts.full) state_nxt = S_OUT;
        else state_nxt = S_SHIFT;
      end
      S_SHIFT: if (sts.shift_done) state_nxt = S_PLACE;
      S_PLACE: state_nxt = S_OUT;
      S_CMP:   if (sts.scan_last) state_nxt = S_TAIL;
      S_TAIL:  state_nxt = S_OUT;
      S_OUT:   if (out_v_r && out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  status_t st_c;
  always_comb begin
    st_c = ST_DONE;
    if (op_r == OP_REQUEST) begin
      if (zero_r || !sts.found) st_c = ST_NO_FIT;
      else if (!sts.exact && full_r) st_c = ST_FULL;
    end else if (op_r == OP_RELEASE) begin
      if (!sts.rel_hit) st_c = ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.load_out) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
  end

  always_comb begin
    cmd = '0;
    cmd.init = init_r || cfg_we;
    cmd.start = in_fire;
    cmd.scan_step = (state_r == S_SCAN) && (op_r == OP_REQUEST);
    cmd.rel_step = (state_r == S_SCAN) && (op_r == OP_RELEASE);
    cmd.shift_step = (state_r == S_SHIFT) && !sts.shift_done;
    cmd.place = (state_r == S_PLACE) ||
                ((state_r == S_SCAN) && sts.scan_last && op_r == OP_REQUEST &&
                 !zero_r && sts.found && sts.exact);
    cmd.cmp_step = (state_r == S_CMP);
    cmd.tail = (state_r == S_TAIL);
    cmd.load_out = (state_r == S_OUT) && !out_v_r;
  end

  assign status = st_c;
  assign busy = (state_r != S_IDLE);
  assign out_tvalid = out_v_r;
endmodule
`default_nettype wire

// ===== rtl/wfsa_checker.sv =====
// wfsa_checker: port-level checks for the allocator core
// depends on worst_fit_segment_allocator_core
`default_nettype none
module wfsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[24:18] != 7'd0)
    else $error("segment count zero");
  a_ps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[17:2] == 16'd0)
    else $error("start set on failure");
endmodule
bind worst_fit_segment_allocator_core wfsa_checker u_chk (.*);
`default_nettype wire

// ===== tb/tb_worst_fit_segment_allocator_core.sv =====
// testbench for worst_fit_segment_allocator_core: drives allocator commands,
// predicts every response with a behavioral segment table and checks results
// depends on wfsa_pkg and the allocator rtl
`timescale 1ns / 1ps
module tb_worst_fit_segment_allocator_core;
  import wfsa_pkg::*;

  localparam int Slots = 64;

  typedef struct packed {
    logic [6:0]  segment_count;
    logic [15:0] placed_start;
    status_t     status;
  } alloc_resp_t;

  class alloc_scoreboard;
    logic [15:0] mem_size;
    bit          is_proc[Slots];
    logic [7:0]  owner[Slots];
    logic [15:0] start[Slots];
    logic [15:0] size[Slots];
    int          used;
    alloc_resp_t pending[$];
    int          errors;

    function void clear_table(logic [15:0] bytes);
      mem_size = bytes;
      foreach (is_proc[i]) begin
        is_proc[i] = 0;
        owner[i] = '0;
        start[i] = '0;
        size[i] = '0;
      end
      size[0] = bytes;
      used = 1;
    endfunction

    function status_t place_owner(logic [7:0] who, logic [15:0] want, output logic [15:0] at);
      int best;
      bit hit;
      best = 0;
      hit = 0;
      at = '0;
      if (want == 0) return ST_NO_FIT;
      for (int i = 0; i < used; i++)
        if (!is_proc[i] && size[i] >= want && (!hit || size[i] > size[best])) begin
          best = i;
          hit = 1;
        end
      if (!hit) return ST_NO_FIT;
      if (size[best] != want) begin
        if (used >= Slots) return ST_FULL;
        for (int i = used; i > best + 1; i--) begin
          is_proc[i] = is_proc[i-1];
          owner[i] = owner[i-1];
          start[i] = start[i-1];
          size[i] = size[i-1];
        end
        is_proc[best+1] = 0;
        owner[best+1] = '0;
        start[best+1] = start[best] + want;
        size[best+1] = size[best] - want;
        size[best] = want;
        used++;
      end
      is_proc[best] = 1;
      owner[best] = who;
      at = start[best];
      return ST_DONE;
    endfunction

    function status_t free_owner(logic [7:0] who);
      for (int i = 0; i < used; i++)
        if (is_proc[i] && owner[i] == who) begin
          is_proc[i] = 0;
          return ST_DONE;
        end
      return ST_NOT_FOUND;
    endfunction

    function void pack_table();
      int n;
      longint addr;
      n = 0;
      addr = 0;
      for (int i = 0; i < used; i++)
        if (is_proc[i]) begin
          is_proc[n] = 1;
          owner[n] = owner[i];
          size[n] = size[i];
          start[n] = addr[15:0];
          addr += size[i];
          n++;
        end
      if (n < Slots && (n == 0 || addr < mem_size)) begin
        is_proc[n] = 0;
        owner[n] = '0;
        start[n] = addr[15:0];
        size[n] = (addr < mem_size) ? 16'(mem_size - addr) : 16'd0;
        n++;
      end
      used = n;
    endfunction

    function void note_command(logic [25:0] cmd);
      alloc_resp_t r;
      logic [15:0] at;
      op_t op;
      op = op_t'(cmd[1:0]);
      r = '0;
      case (op)
        OP_REQUEST: begin
          r.status = place_owner(cmd[9:2], cmd[25:10], at);
          if (r.status == ST_DONE) r.placed_start = at;
        end
        OP_RELEASE: r.status = free_owner(cmd[9:2]);
        OP_COMPACT: pack_table();
        default: r.status = ST_DONE;
      endcase
      r.segment_count = 7'(used);
      pending.push_back(r);
    endfunction

    function void check_response(logic [31:0] data);
      alloc_resp_t got, exp;
      got = data[24:0];
      if (pending.size() == 0) begin
        $error("unexpected transaction %h", data);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.placed_start != exp.placed_start) begin
        $error("placed_start exp %0d got %0d", exp.placed_start, got.placed_start);
        errors++;
      end
      if (got.segment_count != exp.segment_count) begin
        $error("segment_count exp %0d got %0d", exp.segment_count, got.segment_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  alloc_scoreboard sb;
  bit          stall_on;
  int          burst_left;
  logic [7:0]  live_owners[$];

  worst_fit_segment_allocator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("tb_worst_fit_segment_allocator_core NOT OK");
    $finish;
  end

  // receiver stall pattern and response check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
    if ($urandom_range(0, 99) < 3) stall_on <= ~stall_on;
    out_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic send_command(op_t op, logic [7:0] who, logic [15:0] want);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = int'($urandom_range(1, 20));
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, want, who, op};
    do @(posedge clk); while (!in_tready);
    sb.note_command({want, who, op});
    burst_left--;
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    if (burst_left != 0) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_mem_size(logic [15:0] bytes);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.clear_table(bytes);
    live_owners.delete();
  endtask

  task automatic random_command(logic [15:0] bytes);
    int pick;
    logic [7:0] who;
    logic [15:0] want;
    pick = int'($urandom_range(0, 99));
    who = 8'($urandom_range(0, 255));
    if (pick < 50) begin
      case ($urandom_range(0, 5))
        0: want = 16'($urandom);
        1: want = 16'($urandom_range(0, 3));
        default: want = 16'($urandom_range(1, (bytes / 8) + 1));
      endcase
      live_owners.push_back(who);
      send_command(OP_REQUEST, who, want);
    end else if (pick < 85) begin
      if (live_owners.size() != 0 && $urandom_range(0, 4) != 0) begin
        int k;
        k = int'($urandom_range(0, live_owners.size() - 1));
        who = live_owners[k];
        live_owners.delete(k);
      end
      send_command(OP_RELEASE, who, 16'($urandom));
    end else if (pick < 96) begin
      send_command(OP_COMPACT, who, 16'($urandom));
    end else begin
      send_command(OP_NONE, who, 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] sizes[5];
    sb = new();
    sb.errors = 0;
    sb.clear_table(TotalBytesRst);
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    stall_on = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_command(OP_REQUEST, 8'd1, 16'd0);
    send_command(OP_REQUEST, 8'd2, 16'd2000);
    send_command(OP_REQUEST, 8'd255, 16'd100);
    send_command(OP_REQUEST, 8'd0, 16'd200);
    send_command(OP_REQUEST, 8'd7, 16'd100);
    send_command(OP_RELEASE, 8'd0, 16'd0);
    send_command(OP_RELEASE, 8'd99, 16'hffff);
    send_command(OP_REQUEST, 8'd8, 16'd200);
    send_command(OP_RELEASE, 8'd255, 16'd0);
    send_command(OP_COMPACT, 8'd0, 16'd0);
    send_command(OP_NONE, 8'hff, 16'hffff);
    send_command(OP_REQUEST, 8'd9, 16'd624);
    send_command(OP_COMPACT, 8'd0, 16'd0);
    send_command(OP_REQUEST, 8'd3, 16'd1);
    drain_results();

    // fill the table to exercise the full case, then exact fit when full
    set_mem_size(16'd64);
    for (int i = 0; i < 63; i++) send_command(OP_REQUEST, 8'(i), 16'd1);
    send_command(OP_REQUEST, 8'd200, 16'd0);
    send_command(OP_RELEASE, 8'd5, 16'd0);
    send_command(OP_REQUEST, 8'd201, 16'd2);
    send_command(OP_REQUEST, 8'd202, 16'd1);
    send_command(OP_RELEASE, 8'd202, 16'd0);
    send_command(OP_RELEASE, 8'd10, 16'd0);
    send_command(OP_COMPACT, 8'd0, 16'd0);

    set_mem_size(16'hffff);
    send_command(OP_REQUEST, 8'd4, 16'hffff);
    send_command(OP_COMPACT, 8'd0, 16'd0);
    set_mem_size(16'd1);
    send_command(OP_COMPACT, 8'd0, 16'd0);
    send_command(OP_REQUEST, 8'd4, 16'd1);

    sizes = '{16'd1024, 16'd1, 16'd300, 16'hffff, 16'd5000};
    foreach (sizes[s]) begin
      set_mem_size(sizes[s]);
      for (int n = 0; n < 240; n++) random_command(sizes[s]);
    end
    drain_results();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_worst_fit_segment_allocator_core OK");
    else
      $display("tb_worst_fit_segment_allocator_core NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/wfsa_pkg.sv
rtl/wfsa_datapath.sv
rtl/wfsa_ctrl.sv
rtl/worst_fit_segment_allocator_core.sv
rtl/wfsa_checker.sv
tb/tb_worst_fit_segment_allocator_core.sv
